// ===== hw/rtl/eeg_pkg.sv =====
// ----------------------------------------------------------------------------
// eeg_pkg
// Shared types for the extended Euclid gcd block: controller commands and
// datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package eeg_pkg;

  localparam int unsigned CoefWidth = 64;

  typedef struct packed {
    logic load;      // take operands, init coefficients
    logic div_start; // begin one division of the active pair
    logic update;    // apply quotient to remainder and coefficients
    logic swap_dir;  // toggle which remainder is reduced
  } eeg_cmd_t;

  typedef struct packed {
    logic zero_opnd; // an operand is zero after load
    logic div_done;  // quotient ready
    logic rem_zero;  // last reduced remainder became zero
  } eeg_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/eeg_datapath.sv =====
// ----------------------------------------------------------------------------
// eeg_datapath
// Remainders, coefficient pairs and a restoring divider that yields one
// quotient bit per cycle, with shift-add products of the quotient and the
// active coefficients built alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module eeg_datapath import eeg_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire eeg_cmd_t                cmd_i,
  output eeg_stat_t                    stat_o,
  input  wire logic [DATA_WIDTH-2:0]   first_i,
  input  wire logic [DATA_WIDTH-2:0]   second_i,
  output logic      [DATA_WIDTH-2:0]   divisor_o,
  output logic      [CoefWidth-1:0]    coef_first_o,
  output logic      [CoefWidth-1:0]    coef_second_o
);

  localparam int unsigned OW = DATA_WIDTH - 1;
  localparam int unsigned CW = $clog2(OW + 1);

  logic [OW-1:0] x_q, x_d, y_q, y_d;
  logic [CoefWidth-1:0] gx_q, gx_d, gy_q, gy_d, ex_q, ex_d, ey_q, ey_d;
  logic          dir_q, dir_d;   // 0: reduce x by y, 1: reduce y by x
  logic [OW-1:0] rem_q, rem_d, num_q, num_d;
  logic [CoefWidth-1:0] pg_q, pg_d, pe_q, pe_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [OW-1:0] den;
  logic [OW:0]   trial;
  logic [CoefWidth-1:0] mul_g, mul_e;

  assign den   = dir_q ? x_q : y_q;
  assign trial = {rem_q, num_q[OW-1]} - {1'b0, den};
  assign mul_g = dir_q ? gx_q : gy_q;
  assign mul_e = dir_q ? ex_q : ey_q;

  always_comb begin
    x_d = x_q; y_d = y_q; gx_d = gx_q; gy_d = gy_q; ex_d = ex_q; ey_d = ey_q;
    dir_d = dir_q; rem_d = rem_q; num_d = num_q; cnt_d = cnt_q;
    pg_d = pg_q; pe_d = pe_q;
    busy_d = busy_q; done_d = 1'b0;
    if (cmd_i.load) begin
      x_d = first_i; y_d = second_i;
      gx_d = CoefWidth'(1); gy_d = '0; ex_d = '0; ey_d = CoefWidth'(1);
      dir_d = 1'b0;
    end
    if (cmd_i.div_start) begin
      num_d = dir_q ? y_q : x_q;
      rem_d = '0; pg_d = '0; pe_d = '0; cnt_d = CW'(OW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[OW]) rem_d = trial[OW-1:0];
      else            rem_d = {rem_q[OW-2:0], num_q[OW-1]};
      pg_d = {pg_q[CoefWidth-2:0], 1'b0} + (trial[OW] ? '0 : mul_g);
      pe_d = {pe_q[CoefWidth-2:0], 1'b0} + (trial[OW] ? '0 : mul_e);
      num_d = {num_q[OW-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
    if (cmd_i.update) begin
      if (dir_q) begin
        y_d = rem_q; gy_d = gy_q - pg_q; ey_d = ey_q - pe_q;
      end else begin
        x_d = rem_q; gx_d = gx_q - pg_q; ex_d = ex_q - pe_q;
      end
    end
    if (cmd_i.swap_dir) dir_d = ~dir_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; dir_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; dir_q <= dir_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; gx_q <= gx_d; gy_q <= gy_d; ex_q <= ex_d; ey_q <= ey_d;
    rem_q <= rem_d; num_q <= num_d; pg_q <= pg_d; pe_q <= pe_d;
  end

  assign stat_o.zero_opnd = (x_q == '0) || (y_q == '0);
  assign stat_o.div_done  = done_q;
  assign stat_o.rem_zero  = dir_q ? (y_q == '0) : (x_q == '0);

  // after an x reduction hitting zero, the answer is the y side and vice versa
  assign divisor_o     = dir_q ? x_q  : y_q;
  assign coef_first_o  = dir_q ? gx_q : gy_q;
  assign coef_second_o = dir_q ? ex_q : ey_q;

endmodule

`default_nettype wire

// ===== hw/rtl/eeg_ctrl.sv =====
// ----------------------------------------------------------------------------
// eeg_ctrl
// Sequencer for the gcd block: load, divide, update, test, output.
// ----------------------------------------------------------------------------
`default_nettype none

module eeg_ctrl import eeg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output eeg_cmd_t       cmd_o,
  input  wire eeg_stat_t stat_i,
  output logic           bad_o,
  output logic           capture_o,
  output logic           clear_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_UPD    = 6'b001000,
    ST_TEST   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   bad_q, bad_d;

  always_comb begin
    state_d = state_q; bad_d = bad_q; cmd_o = '0; capture_o = 1'b0; clear_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.zero_opnd) begin
          bad_d = 1'b1; capture_o = 1'b1; clear_o = 1'b1; state_d = ST_OUT;
        end else begin
          bad_d = 1'b0; cmd_o.div_start = 1'b1; state_d = ST_DIV;
        end
      end
      ST_DIV: if (stat_i.div_done) begin
        cmd_o.update = 1'b1; state_d = ST_TEST;
      end
      ST_UPD: begin
        cmd_o.swap_dir = 1'b1; cmd_o.div_start = 1'b0; state_d = ST_CHECK;
      end
      ST_TEST: begin
        if (stat_i.rem_zero) begin
          capture_o = 1'b1; state_d = ST_OUT;
        end else begin
          cmd_o.swap_dir = 1'b1; state_d = ST_CHECK;
        end
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign bad_o       = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; bad_q <= 1'b0;
    end else begin
      state_q <= state_d; bad_q <= bad_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/extended_euclid_gcd_top.sv =====
// ----------------------------------------------------------------------------
// extended_euclid_gcd_top
// Gcd with Bezout coefficients for two positive operands.
// ----------------------------------------------------------------------------
// One word in, one word out; a new word is taken only after the last result
// is accepted. Each Euclid step runs a restoring division of DATA_WIDTH-1
// quotient bits on the shared bit-serial divider, then the test and check
// states. A zero operand gives bad_operand_o with all other outputs zero.
`default_nettype none

module extended_euclid_gcd_top import eeg_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [62:0]           first_value_i,
  input  wire logic [62:0]           second_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [62:0]           divisor_o,
  output logic signed [63:0]         coef_first_o,
  output logic signed [63:0]         coef_second_o,
  output logic                       bad_operand_o
);

  eeg_cmd_t  cmd;
  eeg_stat_t stat;
  logic      bad, capture, clear;
  logic [DATA_WIDTH-2:0] dv;
  logic [CoefWidth-1:0]  cf, cs;
  logic [62:0]           div_q;
  logic [63:0]           cf_q, cs_q;

  eeg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .stat_i(stat), .bad_o(bad), .capture_o(capture), .clear_o(clear)
  );

  eeg_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .first_i(first_value_i[DATA_WIDTH-2:0]),
    .second_i(second_value_i[DATA_WIDTH-2:0]),
    .divisor_o(dv), .coef_first_o(cf), .coef_second_o(cs)
  );

  always_ff @(posedge clk_i) begin
    if (capture) begin
      if (clear) begin
        div_q <= '0; cf_q <= '0; cs_q <= '0;
      end else begin
        div_q <= 63'(dv); cf_q <= cf; cs_q <= cs;
      end
    end
  end

  assign divisor_o     = div_q;
  assign coef_first_o  = cf_q;
  assign coef_second_o = cs_q;
  assign bad_operand_o = bad;

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.update)) else $error("load and update together");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> out_valid_o) else $error("capture without result");

endmodule

`default_nettype wire
